// ----- hw/rtl/csae_pkg.sv -----
// Package for the challenge scramble authorization engine.
// Holds command codes, key tables, sizes and the byte map functions.
// No dependencies.
`default_nettype none
package csae_pkg;

    localparam int STORE_BYTES = 256;
    localparam int ROUNDS      = 50;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int ROUND_W     = 8;

    typedef enum logic [3:0] {
        FN_TICK      = 4'd0,
        FN_INIT      = 4'd1,
        FN_SREAD     = 4'd2,
        FN_CHALLENGE = 4'd3,
        FN_RESPONSE  = 4'd4,
        FN_TRANSFORM = 4'd5,
        FN_DWRITE    = 4'd6,
        FN_DREAD     = 4'd7,
        FN_PROVISION = 4'd8
    } t_func;

    typedef logic [7:0] t_byte;
    typedef t_byte t_scr [11];

    // Round operation selected for the shared unit.
    typedef enum logic [1:0] {
        OP_MIX   = 2'd0,
        OP_SROT  = 2'd1,
        OP_RESP  = 2'd2
    } t_op;

    localparam t_byte KEY_A [5] = '{8'h33, 8'hfb, 8'hc7, 8'h52, 8'hc9};
    localparam t_byte KEY_B [5] = '{8'h29, 8'h91, 8'ha7, 8'hf1, 8'h6b};
    localparam t_byte KEY_C [6] = '{8'h8e, 8'h65, 8'he1, 8'ha3, 8'h74, 8'h33};
    localparam t_byte KEY_D [6] = '{8'h1d, 8'he9, 8'h43, 8'h3f, 8'hb8, 8'h29};

    localparam logic [7:0] INIT_BASE = 8'h40;
    localparam logic [7:0] XFRM_BASE = 8'h47;
    localparam logic [7:0] WIN_LO    = 8'h20;
    localparam logic [7:0] WIN_HI    = 8'h3f;

    // x -> 37x + 5
    function automatic t_byte map_a(input t_byte x);
        logic [13:0] p;
        p = 14'(x) * 14'd37 + 14'd5;
        return p[7:0];
    endfunction

    // x -> 173x + 159
    function automatic t_byte map_b(input t_byte x);
        logic [15:0] p;
        p = 16'(x) * 16'd173 + 16'd159;
        return p[7:0];
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/csae_round.sv -----
// One scramble round, the shared unit used once per cycle.
// Depends on csae_pkg.
`default_nettype none
module csae_round (
    input  wire csae_pkg::t_op  i_op,
    input  wire csae_pkg::t_scr i_s,
    output csae_pkg::t_scr      o_s
);
    import csae_pkg::*;

    logic [87:0] w, m;
    logic [39:0] h;
    logic [47:0] g;
    t_scr        r, q;

    always_comb begin
        for (int i = 0; i < 11; i++) r[i] = i_s[i];
        for (int i = 0; i < 11; i++) w[8*i +: 8] = i_s[i];
        m = '0; h = '0; g = '0;
        for (int i = 0; i < 11; i++) q[i] = i_s[i];
        case (i_op)
            OP_MIX: begin
                for (int i = 0; i < 11; i++)
                    m[8*i +: 8] = (i < 6) ? map_a(i_s[i]) : i_s[i];
                m = {m[84:0], m[87:85]};
                for (int i = 0; i < 11; i++) r[i] = m[8*i +: 8];
            end
            OP_SROT: begin
                h = w[87:48];
                h = {h[36:0], h[39:37]};
                for (int i = 0; i < 5; i++) r[6+i] = h[8*i +: 8];
            end
            OP_RESP: begin
                g = w[87:40];
                g = {g[0], g[47:1]};
                for (int i = 0; i < 6; i++) r[5+i] = map_b(g[8*i +: 8]);
            end
            default: begin
                for (int i = 0; i < 11; i++) r[i] = q[i];
            end
        endcase
        o_s = r;
    end
endmodule
`default_nettype wire

// ----- hw/rtl/csae_store.sv -----
// Nonvolatile byte store with a registered read port and per-entry
// written bits standing in for the erased value. Depends on csae_pkg.
`default_nettype none
module csae_store (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_we,
    input  wire [csae_pkg::ADDR_W-1:0]  i_waddr,
    input  wire [7:0]                   i_wdata,
    input  wire [csae_pkg::ADDR_W-1:0]  i_raddr,
    output logic [7:0]                  o_rdata
);
    import csae_pkg::*;

    logic [7:0]             mem [STORE_BYTES];
    logic [STORE_BYTES-1:0] r_vld;
    logic [7:0]             r_rd;
    logic                   r_rv;

    // Memory array: write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
        r_rd <= mem[i_raddr];
    end

    // Written bits; an unwritten entry reads as erased.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_rv  <= 1'b0;
        end else begin
            if (i_we) r_vld[i_waddr] <= 1'b1;
            r_rv <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rv ? r_rd : 8'hff;
endmodule
`default_nettype wire

// ----- hw/rtl/challenge_scramble_auth_engine_core.sv -----
// Top level of the challenge scramble authorization engine: sequencer,
// scramble register, counters and reply buffer. Depends on csae_pkg,
// csae_round and csae_store.
//
// Channel | Direction | Fields
// in      | input     | func, address, data0..data3
// out     | output    | out_byte, last
//
// Init and transform: 7 key bytes loaded from the store, 50 rounds, a finish step,
// then the reply. Scrambled read: a store read, 50 rounds, a finish step, reply.
// Response: 50 rounds and a finish step, no reply. Tick, direct write, provision:
// no reply; direct read: store read, reply if in window; challenge: counter reply.
// Reset is synchronous, active low; the store reads as erased after reset.
// Reply bytes leave one per ready cycle; input is not ready until the last leaves.
`default_nettype none
module challenge_scramble_auth_engine_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire [3:0]  i_func,
    input  wire [7:0]  i_address,
    input  wire [7:0]  i_data0,
    input  wire [7:0]  i_data1,
    input  wire [7:0]  i_data2,
    input  wire [7:0]  i_data3,
    output logic       o_valid,
    input  wire        i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last
);
    import csae_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_ROUND, S_FINISH, S_READ, S_EMIT
    } t_state;

    t_state            r_state;
    t_func             r_func;
    logic [7:0]        r_addr, r_d0;
    t_scr              r_s, rnd_out;
    logic [31:0]       r_cnt, r_chal;
    logic [ROUND_W-1:0] r_rnd;
    logic [2:0]        r_ld;
    t_byte             r_rep [6];
    logic [2:0]        r_nrep, r_idx;
    t_op               op;
    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [7:0]        wdata, rdata, base;

    csae_round u_round (.i_op(op), .i_s(r_s), .o_s(rnd_out));
    csae_store u_store (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(we), .i_waddr(waddr),
        .i_wdata(wdata), .i_raddr(raddr), .o_rdata(rdata)
    );

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = (r_state == S_EMIT);
    assign o_out_byte = r_rep[r_idx];
    assign o_last     = (r_idx == r_nrep - 3'd1);

    // Operation of the shared unit follows the command.
    always_comb begin
        case (r_func)
            FN_SREAD:    op = OP_SROT;
            FN_RESPONSE: op = OP_RESP;
            default:     op = OP_MIX;
        endcase
    end

    // Store read address: key load sequence or the command address.
    assign base  = (r_func == FN_TRANSFORM) ? XFRM_BASE : INIT_BASE;
    assign raddr = (r_state == S_LOAD) ? ADDR_W'(base + 8'(r_ld)) : ADDR_W'(r_addr);

    // Store writes: direct write, provision, and a verified response.
    always_comb begin
        we    = 1'b0;
        waddr = ADDR_W'(r_addr);
        wdata = r_d0;
        if (r_state == S_READ) begin
            if (r_func == FN_PROVISION) we = 1'b1;
            if (r_func == FN_DWRITE && r_addr >= WIN_LO && r_addr <= WIN_HI) we = 1'b1;
        end
        if (r_state == S_FINISH && r_func == FN_RESPONSE) begin
            waddr = ADDR_W'(r_s[6] ^ KEY_B[4]);
            wdata = r_s[5] ^ 8'h1d;
            we = ((r_s[10] ^ KEY_B[0]) == r_chal[7:0])
              && ((r_s[9] ^ KEY_B[1]) == r_chal[15:8])
              && ((r_s[8] ^ KEY_B[2]) == r_chal[23:16])
              && ((r_s[7] ^ KEY_B[3]) == r_chal[31:24])
              && ((r_s[6] ^ KEY_B[4]) < 8'h40);
        end
    end

    // Sequencer, scramble register and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_chal  <= '0;
            r_nrep  <= '0;
            r_idx   <= '0;
            r_ld    <= '0;
            r_rnd   <= '0;
            r_func  <= FN_TICK;
            for (int i = 0; i < 11; i++) r_s[i] <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_func <= t_func'(i_func);
                    r_addr <= i_address;
                    r_d0   <= i_data0;
                    r_ld   <= '0;
                    r_rnd  <= '0;
                    r_idx  <= '0;
                    r_state <= S_IDLE;
                    case (t_func'(i_func))
                        FN_TICK: begin
                            r_cnt[15:0]  <= r_cnt[15:0] + 16'd1;
                            r_cnt[23:16] <= r_cnt[23:16] - 8'd1;
                            if (r_cnt[23:16] == 8'd0) r_cnt[31:24] <= r_cnt[31:24] + 8'd1;
                        end
                        FN_INIT: r_state <= S_LOAD;
                        FN_TRANSFORM: begin
                            r_s[10] <= i_data0 ^ KEY_B[0];
                            r_s[9]  <= i_data1 ^ KEY_B[1];
                            r_s[8]  <= i_data2 ^ KEY_B[2];
                            r_s[7]  <= i_data3 ^ KEY_B[3];
                            r_state <= S_LOAD;
                        end
                        FN_CHALLENGE: begin
                            r_chal <= r_cnt;
                            for (int i = 0; i < 4; i++) r_rep[i] <= r_cnt[8*i +: 8];
                            r_nrep <= 3'd4;
                            r_state <= S_EMIT;
                        end
                        FN_RESPONSE: begin
                            r_s[10] <= r_s[10] ^ KEY_A[0];
                            r_s[9]  <= r_s[9] ^ KEY_A[1];
                            r_s[8]  <= r_s[8] ^ KEY_A[2];
                            r_s[7]  <= r_s[7] ^ KEY_A[3];
                            r_s[6]  <= i_data0 ^ KEY_A[4];
                            r_s[5]  <= i_data1 ^ 8'h8e;
                            r_s[4]  <= i_data2 ^ 8'h65;
                            r_state <= S_ROUND;
                        end
                        FN_SREAD, FN_DWRITE, FN_DREAD, FN_PROVISION: r_state <= S_READ;
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_LOAD: begin
                    // Read data arrives in the cycle after its address.
                    r_ld <= r_ld + 3'd1;
                    if (r_ld != 3'd0) r_s[7 - 32'(r_ld)] <= rdata;
                    if (r_ld == 3'd7) begin
                        if (r_func == FN_TRANSFORM) r_s[6] <= r_s[6] ^ KEY_B[4];
                        for (int i = 0; i < 6; i++)
                            r_s[5-i] <= ((i == 5) ? rdata : r_s[5-i]) ^ KEY_D[i];
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_s <= rnd_out;
                    r_rnd <= r_rnd + ROUND_W'(1);
                    if (r_rnd == ROUND_W'(ROUNDS - 1)) r_state <= S_FINISH;
                end
                S_FINISH: begin
                    r_state <= S_EMIT;
                    case (r_func)
                        FN_SREAD: begin
                            for (int i = 0; i < 5; i++) begin
                                r_s[10-i] <= r_s[10-i] ^ KEY_A[i];
                                r_rep[4-i] <= r_s[10-i] ^ KEY_A[i];
                            end
                            r_nrep <= 3'd5;
                        end
                        FN_RESPONSE: begin
                            for (int i = 0; i < 5; i++) r_s[10-i] <= r_s[10-i] ^ KEY_B[i];
                            r_s[5] <= r_s[5] ^ 8'h1d;
                            r_state <= S_IDLE;
                        end
                        FN_INIT, FN_TRANSFORM: begin
                            for (int i = 0; i < 5; i++) r_s[10-i] <= r_s[10-i] ^ KEY_A[i];
                            for (int i = 0; i < 6; i++) begin
                                r_s[5-i] <= r_s[5-i] ^ KEY_C[i];
                                r_rep[i] <= r_s[5-i] ^ KEY_C[i];
                            end
                            r_nrep <= 3'd6;
                        end
                        default: begin
                        end
                    endcase
                end
                S_READ: begin
                    // Wait state: read data appears next cycle; writes happen here.
                    r_state <= S_IDLE;
                    if (r_func == FN_SREAD || r_func == FN_DREAD) r_state <= S_FINISH;
                    if (r_func == FN_DREAD) r_ld <= 3'd1;
                    if (r_func == FN_SREAD) r_ld <= 3'd2;
                end
                default: begin
                    if (i_ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (o_last) r_state <= S_IDLE;
                    end
                end
            endcase
            // Second step after a read: data is valid now.
            if (r_state == S_FINISH && r_ld == 3'd1) begin
                r_rep[0] <= rdata;
                r_nrep   <= 3'd1;
                r_ld     <= '0;
                r_state  <= (r_addr >= WIN_LO && r_addr <= WIN_HI) ? S_EMIT : S_IDLE;
            end
            if (r_state == S_FINISH && r_ld == 3'd2) begin
                r_s[6]  <= rdata ^ KEY_B[4];
                for (int i = 0; i < 4; i++) r_s[10-i] <= r_s[10-i] ^ KEY_B[i];
                r_ld    <= '0;
                r_rnd   <= '0;
                r_state <= S_ROUND;
            end
        end
    end
endmodule
`default_nettype wire

// ----- sim/csae_checker.sv -----
// Reply checker for the challenge scramble authorization engine.
// Watches both channels, predicts reply bytes per command and compares them.
// Depends on csae_pkg for command codes and key tables.
`default_nettype none
module csae_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cmd_valid,
    input  wire        i_cmd_ready,
    input  wire [3:0]  i_func,
    input  wire [7:0]  i_address,
    input  wire [7:0]  i_data0,
    input  wire [7:0]  i_data1,
    input  wire [7:0]  i_data2,
    input  wire [7:0]  i_data3,
    input  wire        i_rep_valid,
    input  wire        i_rep_ready,
    input  wire [7:0]  i_rep_byte,
    input  wire        i_rep_last,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import csae_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_reply_byte;

    // Predicted engine state.
    logic [7:0]  scr [11];
    logic [31:0] counter;
    logic [31:0] latched;
    logic [7:0]  nvm [STORE_BYTES];

    t_reply_byte reply_q [$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = reply_q.size();

    task automatic add_reply(input logic [7:0] value);
        t_reply_byte r;
        r.value = value;
        r.last  = 1'b0;
        reply_q.push_back(r);
    endtask

    // Load seven store bytes into scramble bytes 6 down to 0.
    task automatic load_key(input logic [7:0] base);
        for (int i = 0; i < 7; i++) begin
            scr[6 - i] = nvm[8'(base + i)];
        end
    endtask

    task automatic xor_top(input bit use_a);
        for (int i = 0; i < 5; i++) begin
            scr[10 - i] ^= use_a ? KEY_A[i] : KEY_B[i];
        end
    endtask

    // Apply one command to the predicted state and queue its reply bytes.
    task automatic run_command(input logic [3:0] func, input logic [7:0] addr,
                               input logic [7:0] d0, input logic [7:0] d1,
                               input logic [7:0] d2, input logic [7:0] d3);
        logic [87:0] whole;
        logic [39:0] upper;
        logic [47:0] resp;
        logic [7:0]  c [4];
        int          queued;
        queued = reply_q.size();
        case (func)
            FN_TICK: begin
                for (int i = 0; i < 4; i++) c[i] = counter[8*i +: 8];
                c[0] = c[0] + 8'd1;
                if (c[0] == 8'd0) c[1] = c[1] + 8'd1;
                if (c[2] == 8'd0) c[3] = c[3] + 8'd1;
                c[2] = c[2] - 8'd1;
                counter = {c[3], c[2], c[1], c[0]};
            end
            FN_INIT, FN_TRANSFORM: begin
                if (func == FN_TRANSFORM) begin
                    scr[10] = d0;
                    scr[9]  = d1;
                    scr[8]  = d2;
                    scr[7]  = d3;
                    load_key(XFRM_BASE);
                    xor_top(1'b0);
                end else begin
                    load_key(INIT_BASE);
                end
                for (int i = 0; i < 6; i++) scr[5 - i] ^= KEY_D[i];
                for (int r = 0; r < ROUNDS; r++) begin
                    for (int i = 0; i < 6; i++) scr[i] = 8'(scr[i] * 8'd37 + 8'd5);
                    for (int i = 0; i < 11; i++) whole[8*i +: 8] = scr[i];
                    whole = {whole[84:0], whole[87:85]};
                    for (int i = 0; i < 11; i++) scr[i] = whole[8*i +: 8];
                end
                xor_top(1'b1);
                for (int i = 0; i < 6; i++) scr[5 - i] ^= KEY_C[i];
                for (int i = 0; i < 6; i++) add_reply(scr[5 - i]);
            end
            FN_SREAD: begin
                scr[6] = nvm[addr];
                xor_top(1'b0);
                for (int i = 0; i < 5; i++) upper[8*i +: 8] = scr[6 + i];
                for (int r = 0; r < ROUNDS; r++) upper = {upper[36:0], upper[39:37]};
                for (int i = 0; i < 5; i++) scr[6 + i] = upper[8*i +: 8];
                xor_top(1'b1);
                for (int i = 0; i < 5; i++) add_reply(scr[6 + i]);
            end
            FN_CHALLENGE: begin
                latched = counter;
                for (int i = 0; i < 4; i++) add_reply(latched[8*i +: 8]);
            end
            FN_RESPONSE: begin
                scr[6] = d0;
                scr[5] = d1;
                scr[4] = d2;
                xor_top(1'b1);
                scr[5] ^= 8'h8e;
                scr[4] ^= 8'h65;
                for (int r = 0; r < ROUNDS; r++) begin
                    for (int i = 0; i < 6; i++) resp[8*i +: 8] = scr[5 + i];
                    resp = {resp[0], resp[47:1]};
                    for (int i = 0; i < 6; i++) begin
                        scr[5 + i] = 8'(resp[8*i +: 8] * 8'd173 + 8'd159);
                    end
                end
                xor_top(1'b0);
                scr[5] ^= 8'h1d;
                // Store only when the answer reproduces the latched challenge.
                if ({scr[7], scr[8], scr[9], scr[10]} == latched && scr[6] < 8'h40) begin
                    nvm[scr[6]] = scr[5];
                end
            end
            FN_DWRITE: begin
                if (addr >= WIN_LO && addr <= WIN_HI) nvm[addr] = d0;
            end
            FN_DREAD: begin
                if (addr >= WIN_LO && addr <= WIN_HI) add_reply(nvm[addr]);
            end
            FN_PROVISION: begin
                nvm[addr] = d0;
            end
            default: begin
            end
        endcase
        if (reply_q.size() > queued) reply_q[reply_q.size() - 1].last = 1'b1;
    endtask

    // Track accepted commands and check every accepted reply byte.
    always @(posedge i_clk) begin
        t_reply_byte want;
        if (!i_rst_n) begin
            for (int i = 0; i < 11; i++) scr[i] = 8'd0;
            for (int i = 0; i < STORE_BYTES; i++) nvm[i] = 8'hff;
            counter = 32'd0;
            latched = 32'd0;
            reply_q.delete();
            fails   = 0;
        end else begin
            if (i_rep_valid && i_rep_ready) begin
                if (reply_q.size() == 0) begin
                    $display("%0t: unexpected reply byte %h last %b", $time,
                             i_rep_byte, i_rep_last);
                    fails++;
                end else begin
                    want = reply_q.pop_front();
                    if (want.value !== i_rep_byte) begin
                        $display("%0t: reply byte expected %h actual %h", $time,
                                 want.value, i_rep_byte);
                        fails++;
                    end
                    if (want.last !== i_rep_last) begin
                        $display("%0t: last flag expected %b actual %b", $time,
                                 want.last, i_rep_last);
                        fails++;
                    end
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                run_command(i_func, i_address, i_data0, i_data1, i_data2, i_data3);
            end
        end
    end

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Testbench top for the challenge scramble authorization engine core.
// Drives commands with random gaps and reply stalls; csae_checker predicts and
// checks. Depends on csae_pkg, csae_checker and the engine RTL.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csae_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [3:0] i_func;
    logic [7:0] i_address;
    logic [7:0] i_data0;
    logic [7:0] i_data1;
    logic [7:0] i_data2;
    logic [7:0] i_data3;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_out_byte;
    logic       o_last;

    int fail_count;
    int pending;
    int gap_pct;
    int stall_pct;
    int hold_left;
    int cycles;
    logic hold_go;

    challenge_scramble_auth_engine_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_func     (i_func),
        .i_address  (i_address),
        .i_data0    (i_data0),
        .i_data1    (i_data1),
        .i_data2    (i_data2),
        .i_data3    (i_data3),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

    csae_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (i_valid),
        .i_cmd_ready  (o_ready),
        .i_func       (i_func),
        .i_address    (i_address),
        .i_data0      (i_data0),
        .i_data1      (i_data1),
        .i_data2      (i_data2),
        .i_data3      (i_data3),
        .i_rep_valid  (o_valid),
        .i_rep_ready  (i_ready),
        .i_rep_byte   (o_out_byte),
        .i_rep_last   (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Reply side: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        if (!i_rst_n || hold_go || hold_left > 1) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Cycle limit guards against a hung engine.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one command item and wait until the engine takes it.
    task automatic send_cmd(input logic [3:0] func, input logic [7:0] addr,
                            input logic [7:0] d0, input logic [7:0] d1,
                            input logic [7:0] d2, input logic [7:0] d3);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_func    <= func;
        i_address <= addr;
        i_data0   <= d0;
        i_data1   <= d1;
        i_data2   <= d2;
        i_data3   <= d3;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Stop offering and wait until every predicted reply byte has arrived.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_addr();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return 8'($urandom_range(8'h3f, 8'h20));
            5, 6:          return 8'($urandom_range(8'h4d, 8'h40));
            default:       return 8'($urandom);
        endcase
    endfunction

    // One random item, or a short well-formed sequence of them.
    task automatic random_burst(inout int sent);
        logic [7:0] a;
        logic [3:0] f;
        a = pick_addr();
        case ($urandom_range(9))
            0, 1: begin
                send_cmd(FN_CHALLENGE, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
                send_cmd(FN_RESPONSE, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
                sent += 2;
            end
            2, 3: begin
                send_cmd(FN_DWRITE, a, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
                send_cmd(FN_DREAD, a, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
                sent += 2;
            end
            4: begin
                send_cmd(FN_PROVISION, 8'($urandom_range(8'h4d, 8'h40)), 8'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom));
                f = $urandom_range(1) ? FN_INIT : FN_TRANSFORM;
                send_cmd(f, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
                sent += 2;
            end
            default: begin
                // Mostly defined codes, now and then an unused one.
                f = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9))
                                              : 4'($urandom_range(8));
                send_cmd(f, a, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
                sent += 1;
            end
        endcase
    endtask

    initial begin
        int sent;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_ready   = 1'b0;
        i_func    = FN_TICK;
        i_address = 8'd0;
        i_data0   = 8'd0;
        i_data1   = 8'd0;
        i_data2   = 8'd0;
        i_data3   = 8'd0;
        hold_go   = 1'b0;
        hold_left = 0;
        cycles    = 0;
        gap_pct   = 0;
        stall_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed commands: erased store, window edges, unused codes.
        send_cmd(FN_RESPONSE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(FN_CHALLENGE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(FN_INIT,      8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        send_cmd(FN_SREAD,     8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(FN_SREAD,     8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        send_cmd(FN_DWRITE,    WIN_LO, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(FN_DWRITE,    WIN_HI, 8'hff, 8'h00, 8'h00, 8'h00);
        send_cmd(FN_DWRITE,    8'h1f, 8'h5a, 8'h00, 8'h00, 8'h00);
        send_cmd(FN_DWRITE,    8'h40, 8'ha5, 8'h00, 8'h00, 8'h00);
        send_cmd(FN_DREAD,     WIN_LO, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(FN_DREAD,     WIN_HI, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(FN_DREAD,     8'h1f, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(FN_DREAD,     8'h40, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(FN_PROVISION, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(FN_PROVISION, 8'hff, 8'h12, 8'h00, 8'h00, 8'h00);
        send_cmd(FN_PROVISION, 8'h4d, 8'hff, 8'h00, 8'h00, 8'h00);
        send_cmd(FN_TRANSFORM, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(FN_TRANSFORM, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        send_cmd(FN_INIT,      8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(4'd9,         8'h20, 8'hff, 8'hff, 8'hff, 8'hff);
        send_cmd(4'd15,        8'h30, 8'hff, 8'hff, 8'hff, 8'hff);
        send_cmd(FN_SREAD,     8'hff, 8'h00, 8'h00, 8'h00, 8'h00);

        // A run of ticks ahead of a challenge and its response.
        repeat (40) send_cmd(FN_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom));
        send_cmd(FN_CHALLENGE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(FN_RESPONSE,  8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        drain();

        // Random phases with different gap and stall rates.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin gap_pct = 0;  stall_pct <= 0;  end
                1:       begin gap_pct = 78; stall_pct <= 0;  end
                2:       begin gap_pct = 0;  stall_pct <= 78; end
                default: begin gap_pct = 31; stall_pct <= 31; end
            endcase
            if (phase == 0) begin
                // Long reply hold-off while commands keep coming.
                hold_go <= 1'b1;
                @(posedge i_clk);
                hold_go <= 1'b0;
            end
            sent = 0;
            while (sent < 26) random_burst(sent);
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
hw/rtl/csae_pkg.sv
hw/rtl/csae_round.sv
hw/rtl/csae_store.sv
hw/rtl/challenge_scramble_auth_engine_core.sv
sim/csae_checker.sv
sim/tb.sv
